// File: rtl/bfa_pkg.sv
// Shared constants, codes and types of the bitmap frame allocator.
package bfa_pkg;

  // Storage geometry: one bit per frame, packed into words.
  localparam int unsigned MAX_FRAMES = 32768;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned NUM_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int unsigned BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int unsigned FRAME_W    = WORD_IDX_W + BIT_IDX_W;
  localparam int unsigned LIMIT_W    = FRAME_W + 1;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;

  // Memory word: reserved bits in the upper half, used bits in the lower half.
  localparam int unsigned MEM_W = 2 * WORD_BITS;

  localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(MAX_FRAMES);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_MAPPED    = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_FREED     = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_RESERVED  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW
  } state_e;

  // Outcome of searching one bitmap word for a free frame.
  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } scan_res_t;

endpackage

// File: rtl/bfa_bitmap_ram.sv
// Bitmap storage: one write port and one registered read port.
module bfa_bitmap_ram import bfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [WORD_IDX_W-1:0] waddr_i,
  input  logic [MEM_W-1:0]      wdata_i,
  input  logic [WORD_IDX_W-1:0] raddr_i,
  output logic [MEM_W-1:0]      rdata_o
);

  logic [MEM_W-1:0] mem [NUM_WORDS];
  logic [MEM_W-1:0] rdata_q;

  // Write and read in the same clocked block; a read sees the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bfa_scan_unit.sv
// Word search unit: finds the lowest frame in one word that is free and below the limit.
module bfa_scan_unit import bfa_pkg::*; (
  input  logic [WORD_BITS-1:0]  used_i,
  input  logic [WORD_BITS-1:0]  rsvd_i,
  input  logic [WORD_IDX_W-1:0] word_i,
  input  logic [LIMIT_W-1:0]    limit_i,
  output scan_res_t             res_o
);

  logic [LIMIT_W-BIT_IDX_W-1:0] lim_word;
  logic [LIMIT_W-BIT_IDX_W-1:0] cur_word;
  logic [WORD_BITS-1:0]         lim_mask;
  logic [WORD_BITS-1:0]         free_bits;
  logic [BIT_IDX_W-1:0]         idx;

  assign lim_word = limit_i[LIMIT_W-1:BIT_IDX_W];
  assign cur_word = {1'b0, word_i};

  // Frames at or above the limit are masked off; only the limit's own word is partial.
  always_comb begin
    if (cur_word < lim_word) begin
      lim_mask = '1;
    end else if (cur_word == lim_word) begin
      lim_mask = (WORD_BITS'(1) << limit_i[BIT_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      lim_mask = '0;
    end
  end

  assign free_bits = ~(used_i | rsvd_i) & lim_mask;

  // Priority encoder: the lowest free bit wins.
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
  end

  assign res_o.found   = |free_bits;
  assign res_o.bit_idx = idx;

endmodule

// File: rtl/bitmap_frame_allocator_top.sv
// Top level of the first-fit bitmap page-frame allocator.
//
//   Channel   Signals                                  Handshake
//   -------   --------------------------------------   ------------------------------
//   request   kind, current_frame, frame_index,        beat taken when start && !busy
//             kernel_page, writable
//   result    frame_out, present_bit, rw_bit,          beat shown for one cycle with done_o
//             user_bit, status
//   config    cfg_wdata_i (num_frames)                 written when cfg_we_i is high
//
// An allocation for an unmapped page scans the bitmap memory one word per cycle through
// its registered read port until the first word with a free frame or the last word below
// the limit. A free of a nonzero frame and a reserve read their word while idle and do a
// read-modify-write of it in S_RMW; the remaining requests answer from the idle state.
// After reset a clearing pass writes all 1024 words, and busy stays high during it.
// The receiver cannot stall; each result is shown exactly once.
module bitmap_frame_allocator_top import bfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [FRAME_W-1:0]  current_frame_i,
  input  logic [FRAME_W-1:0]  frame_index_i,
  input  logic                kernel_page_i,
  input  logic                writable_i,
  output logic [FRAME_W-1:0]  frame_out_o,
  output logic                present_bit_o,
  output logic                rw_bit_o,
  output logic                user_bit_o,
  output logic [STATUS_W-1:0] status_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  state_e                state_q, state_d;
  logic [CFG_W-1:0]      num_frames_q;
  logic [WORD_IDX_W-1:0] clr_q, clr_d;
  logic [WORD_IDX_W-1:0] iss_q, iss_d;
  logic [WORD_IDX_W-1:0] ev_q, ev_d;
  logic                  ev_vld_q, ev_vld_d;
  logic [LIMIT_W-1:0]    limit_q, limit_d;
  logic [WORD_IDX_W-1:0] last_q, last_d;
  logic                  kernel_q, kernel_d;
  logic                  wr_q, wr_d;
  logic                  rsv_op_q, rsv_op_d;
  logic [WORD_IDX_W-1:0] tgt_word_q, tgt_word_d;
  logic [BIT_IDX_W-1:0]  tgt_bit_q, tgt_bit_d;

  logic                  done_q, done_d;
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic                  present_q, present_d;
  logic                  rw_q, rw_d;
  logic                  user_q, user_d;
  status_e               status_q, status_d;

  logic                  accept;
  logic [LIMIT_W-1:0]    cfg_limit;
  logic [LIMIT_W-1:0]    cfg_limit_m1;
  logic                  ram_we;
  logic [WORD_IDX_W-1:0] ram_waddr;
  logic [MEM_W-1:0]      ram_wdata;
  logic [WORD_IDX_W-1:0] ram_raddr;
  logic [MEM_W-1:0]      ram_rdata;
  logic [WORD_BITS-1:0]  rd_used;
  logic [WORD_BITS-1:0]  rd_rsvd;
  logic [WORD_BITS-1:0]  tgt_onehot;
  logic [WORD_BITS-1:0]  hit_onehot;
  scan_res_t             scan_res;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign rd_used = ram_rdata[WORD_BITS-1:0];
  assign rd_rsvd = ram_rdata[MEM_W-1:WORD_BITS];

  // Search limit is the configured frame count, clipped to the storage size.
  assign cfg_limit    = (num_frames_q > NUM_FRAMES_RST) ? LIMIT_W'(MAX_FRAMES)
                                                        : LIMIT_W'(num_frames_q);
  assign cfg_limit_m1 = cfg_limit - LIMIT_W'(1);

  assign tgt_onehot = WORD_BITS'(1) << tgt_bit_q;
  assign hit_onehot = WORD_BITS'(1) << scan_res.bit_idx;

  bfa_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_scan_unit u_scan (
    .used_i  (rd_used),
    .rsvd_i  (rd_rsvd),
    .word_i  (ev_q),
    .limit_i (limit_q),
    .res_o   (scan_res)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= NUM_FRAMES_RST;
    end else if (cfg_we_i) begin
      num_frames_q <= cfg_wdata_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ev_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ev_vld_q <= ev_vld_d;
      done_q   <= done_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    ev_q       <= ev_d;
    limit_q    <= limit_d;
    last_q     <= last_d;
    kernel_q   <= kernel_d;
    wr_q       <= wr_d;
    rsv_op_q   <= rsv_op_d;
    tgt_word_q <= tgt_word_d;
    tgt_bit_q  <= tgt_bit_d;
    frame_q    <= frame_d;
    present_q  <= present_d;
    rw_q       <= rw_d;
    user_q     <= user_d;
    status_q   <= status_d;
  end

  // Sequencer: clearing pass, request decode, word scan and read-modify-write.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    iss_d      = iss_q;
    ev_d       = iss_q;
    ev_vld_d   = 1'b0;
    limit_d    = limit_q;
    last_d     = last_q;
    kernel_d   = kernel_q;
    wr_d       = wr_q;
    rsv_op_d   = rsv_op_q;
    tgt_word_d = tgt_word_q;
    tgt_bit_d  = tgt_bit_q;

    done_d     = 1'b0;
    frame_d    = frame_q;
    present_d  = present_q;
    rw_d       = rw_q;
    user_d     = user_q;
    status_d   = status_q;

    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_wdata  = '0;
    ram_raddr  = iss_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + WORD_IDX_W'(1);
        if (clr_q == WORD_IDX_W'(NUM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        // Fetch the word a free or reserve will modify.
        if (kind_i == KIND_RESERVE) begin
          ram_raddr = frame_index_i[FRAME_W-1:BIT_IDX_W];
        end else begin
          ram_raddr = current_frame_i[FRAME_W-1:BIT_IDX_W];
        end
        if (accept) begin
          frame_d   = '0;
          present_d = 1'b0;
          rw_d      = 1'b0;
          user_d    = 1'b0;
          kernel_d  = kernel_page_i;
          wr_d      = writable_i;
          iss_d     = '0;
          limit_d   = cfg_limit;
          last_d    = cfg_limit_m1[FRAME_W-1:BIT_IDX_W];
          priority if (kind_i == KIND_ALLOC) begin
            if (current_frame_i != '0) begin
              done_d   = 1'b1;
              frame_d  = current_frame_i;
              status_d = ST_MAPPED;
            end else if (cfg_limit == '0) begin
              done_d   = 1'b1;
              status_d = ST_NO_FREE;
            end else begin
              state_d = S_SCAN;
            end
          end else if (kind_i == KIND_FREE) begin
            if (current_frame_i != '0) begin
              rsv_op_d   = 1'b0;
              tgt_word_d = current_frame_i[FRAME_W-1:BIT_IDX_W];
              tgt_bit_d  = current_frame_i[BIT_IDX_W-1:0];
              state_d    = S_RMW;
            end else begin
              done_d   = 1'b1;
              status_d = ST_IGNORED;
            end
          end else if (kind_i == KIND_RESERVE) begin
            rsv_op_d   = 1'b1;
            tgt_word_d = frame_index_i[FRAME_W-1:BIT_IDX_W];
            tgt_bit_d  = frame_index_i[BIT_IDX_W-1:0];
            state_d    = S_RMW;
          end else begin
            done_d   = 1'b1;
            status_d = ST_IGNORED;
          end
        end
      end

      S_SCAN: begin
        // Issue one word read per cycle and test the word read the cycle before.
        ram_raddr = iss_q;
        iss_d     = iss_q + WORD_IDX_W'(1);
        ev_d      = iss_q;
        ev_vld_d  = 1'b1;
        if (ev_vld_q) begin
          if (scan_res.found) begin
            ram_we    = 1'b1;
            ram_waddr = ev_q;
            ram_wdata = {rd_rsvd, rd_used | hit_onehot};
            done_d    = 1'b1;
            frame_d   = {ev_q, scan_res.bit_idx};
            present_d = 1'b1;
            rw_d      = wr_q;
            user_d    = !kernel_q;
            status_d  = ST_ALLOCATED;
            ev_vld_d  = 1'b0;
            state_d   = S_IDLE;
          end else if (ev_q == last_q) begin
            done_d   = 1'b1;
            status_d = ST_NO_FREE;
            ev_vld_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end

      S_RMW: begin
        // The target word arrived; write it back with one bit changed.
        ram_we    = 1'b1;
        ram_waddr = tgt_word_q;
        done_d    = 1'b1;
        if (rsv_op_q) begin
          ram_wdata = {rd_rsvd | tgt_onehot, rd_used};
          status_d  = ST_RESERVED;
        end else begin
          ram_wdata = {rd_rsvd, rd_used & ~tgt_onehot};
          status_d  = ST_FREED;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o        = done_q;
  assign frame_out_o   = frame_q;
  assign present_bit_o = present_q;
  assign rw_bit_o      = rw_q;
  assign user_bit_o    = user_q;
  assign status_o      = status_q;

endmodule

// File: rtl/bfa_checker.sv
// Port-level checks of the frame allocator, bound to the top level.
module bfa_checker import bfa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [KIND_W-1:0]   kind_i,
  input logic [FRAME_W-1:0]  current_frame_i,
  input logic [FRAME_W-1:0]  frame_out_o,
  input logic                present_bit_o,
  input logic                rw_bit_o,
  input logic                user_bit_o,
  input logic [STATUS_W-1:0] status_o
);

  logic accept;
  assign accept = start && !busy;

  // A result beat carries a defined status code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= STATUS_W'(ST_RESERVED)))
    else $error("result beat with undefined status");

  // Page flags appear only on a successful allocation, which always sets present.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_ALLOCATED) == present_bit_o) &&
               ((status_o == ST_ALLOCATED) || (!rw_bit_o && !user_bit_o)))
    else $error("page flags do not match status");

  // An allocation for a page that already holds a frame answers in the next cycle.
  a_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_ALLOC) && (current_frame_i != '0)) |=>
      done_o && (status_o == ST_MAPPED) && (frame_out_o == $past(current_frame_i)))
    else $error("already-mapped allocation answered wrongly");

  // A free of a real frame answers through the read-modify-write state with a zero frame.
  a_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_FREE) && (current_frame_i != '0)) |-> ##2
      done_o && (status_o == ST_FREED) && (frame_out_o == '0))
    else $error("free answered wrongly");

  // A reserve answers through the read-modify-write state.
  a_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_RESERVE)) |-> ##2 done_o && (status_o == ST_RESERVED))
    else $error("reserve answered wrongly");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);
